// ----- rtl/core/hexr_pkg.sv -----
// Package for the excess-64 hex real to binary64 converter.
// Holds field widths and conversion constants; no dependencies.
`timescale 1ns / 1ps
package hexr_pkg;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned FRAC_W     = 56;
  localparam int unsigned SIG_W      = 53;
  localparam int unsigned LEAD_W     = 6;
  localparam int unsigned BEXP_W     = 11;
  localparam logic [6:0]  EXP_EXCESS = 7'd64;
  localparam logic [10:0] EXP_BASE   = 11'd711; // 1023 - 4*(64+14)
endpackage

// ----- rtl/core/hexr_convert.sv -----
// Combinational core: leading-one search, normalize, round to nearest even.
// Depends on hexr_pkg.
`timescale 1ns / 1ps
module hexr_convert (
  input  logic [hexr_pkg::WORD_W-1:0] raw_word,
  output logic [hexr_pkg::WORD_W-1:0] ieee_bits
);
  import hexr_pkg::*;

  logic              sign;
  logic [6:0]        hexexp;
  logic [FRAC_W-1:0] frac;
  logic [LEAD_W-1:0] lead;
  logic [FRAC_W-1:0] norm;
  logic [SIG_W:0]    sig_rnd;
  logic [2:0]        lost;
  logic [BEXP_W-1:0] bexp;
  logic              rnd_up;

  assign sign   = raw_word[63];
  assign hexexp = raw_word[62:56];
  assign frac   = raw_word[FRAC_W-1:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (frac[i]) lead = LEAD_W'(i);
    end
  end

  // norm holds the leading one at bit 55; low 3 bits are the dropped bits
  assign norm = frac << (LEAD_W'(FRAC_W - 1) - lead);
  assign lost = norm[2:0];
  assign rnd_up = lost[2] & ((lost[1:0] != 2'b00) | norm[3]);
  assign sig_rnd = {1'b0, norm[FRAC_W-1:3]} + (SIG_W+1)'(rnd_up);
  assign bexp = EXP_BASE + BEXP_W'(lead) + BEXP_W'({hexexp, 2'b00})
              + BEXP_W'(sig_rnd[SIG_W]);

  always_comb begin
    if (frac == '0) begin
      ieee_bits = {sign, 63'd0};
    end else if (sig_rnd[SIG_W]) begin
      ieee_bits = {sign, bexp, sig_rnd[SIG_W-1:1]};
    end else begin
      ieee_bits = {sign, bexp, sig_rnd[SIG_W-2:0]};
    end
  end
endmodule

// ----- rtl/core/hex_excess64_real_to_ieee_double.sv -----
// Top level: excess-64 hex real (8-byte stream real) to IEEE 754 binary64.
// Depends on hexr_pkg and hexr_convert.
//
// Usage:
//   Input channel in_valid / in_stall / in_raw_word carries one stream real
//   per transaction. Output channel out_valid / out_stall / out_ieee_bits
//   carries its binary64 encoding, one result per input, in order.
//   The input register holds the accepted stream real; the conversion logic
//   feeds the result register, which drives out_ieee_bits and is taken
//   when out_valid is high and out_stall is low.
//   Throughput: one transaction per cycle; the two-stage register pipeline
//   advances whenever the result register is empty or being taken.
//   An output stall holds a full result stage and a full input stage behind
//   it; in_stall rises only if both stages are full and the output stalls.
//   Reset (synchronous, rst_n low) empties both stages; data registers are not reset.
`timescale 1ns / 1ps
module hex_excess64_real_to_ieee_double (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hexr_pkg::WORD_W-1:0]  in_raw_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hexr_pkg::WORD_W-1:0]  out_ieee_bits
);
  import hexr_pkg::*;

  logic              a_vld_r, b_vld_r;
  logic [WORD_W-1:0] a_word_r, b_bits_r;
  logic [WORD_W-1:0] conv_bits;
  logic              b_adv, a_adv;

  hexr_convert u_conv (.raw_word(a_word_r), .ieee_bits(conv_bits));

  assign b_adv    = !b_vld_r || !out_stall;
  assign a_adv    = !a_vld_r || b_adv;
  assign in_stall = !a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (b_adv) b_vld_r <= a_vld_r;
      if (a_adv) a_vld_r <= in_valid;
    end
    if (b_adv && a_vld_r) b_bits_r <= conv_bits;
    if (a_adv && in_valid) a_word_r <= in_raw_word;
  end

  assign out_valid     = b_vld_r;
  assign out_ieee_bits = b_bits_r;
endmodule

// ----- rtl/core/hexr_checker.sv -----
// Port-level checker for the hex real converter, bound to the top level.
// Depends on hex_excess64_real_to_ieee_double ports only.
`timescale 1ns / 1ps
module hexr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [63:0] in_raw_word,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_ieee_bits
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ieee_bits))
    else $error("result changed under stall");
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
  a_zero_map: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_raw_word[55:0] == 56'd0 && !out_stall
    ##1 !out_stall |=> out_valid && out_ieee_bits[62:0] == 63'd0)
    else $error("zero mantissa not mapped to signed zero");
endmodule

bind hex_excess64_real_to_ieee_double hexr_checker u_hexr_checker (.*);
